FILE: rtl/bbg_pkg.sv
// ----------------------------------------------------------------------------
// bbg_pkg: shared types and constants of the 3x3 box blur
// Config register codes, stream payloads, queue entry format and the
// fixed-point constants of the nine-pixel mean.
// ----------------------------------------------------------------------------
package bbg_pkg;

  // Widths fixed by the register map and payload fields
  localparam int LINE_WIDTH_W   = 13;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int PIXEL_W        = 8;
  localparam int HSUM_W         = 10;  // sum of three pixels
  localparam int NSUM_W         = 12;  // sum of nine pixels, plus rounding one
  localparam int ROW_W          = 16;
  localparam int COL_W          = 12;

  // Line store depth default
  localparam int MAX_WIDTH_DEF  = 4096;

  // Decoupling queue depth (power of two)
  localparam int QUEUE_DEPTH    = 4;

  // APB
  localparam int APB_ADDR_W     = 4;
  localparam int APB_DATA_W     = 32;

  // Register reset values
  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 13'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [PIXEL_W-1:0]        BORDER_VALUE_RST = 8'd0;

  // Mean of nine: (s * MEAN_MUL + MEAN_MUL) >> MEAN_SHIFT
  localparam int MEAN_SHIFT = 16;
  localparam int MEAN_MUL_I = 65536 / 9;
  localparam int MEAN_MUL_W = 13;
  localparam logic [MEAN_MUL_W-1:0] MEAN_MUL = MEAN_MUL_W'(MEAN_MUL_I);

  // Command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_LINE_WIDTH,
    REG_FRAME_HEIGHT,
    REG_BORDER_VALUE
  } reg_idx_e;

  typedef struct packed {
    logic [LINE_WIDTH_W-1:0]   line_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic [PIXEL_W-1:0]        border_value;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] blurred;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               end_of_line;
    logic               end_of_frame;
    logic               last_of_run;
  } out_item_t;

  // One column operation handed from the front end to the back end.
  //   emit : produce a result from older + newer + hsum
  //   wr   : update the line stores of this column
  //   row0 : first row, older store takes the border sum
  typedef struct packed {
    logic              emit;
    logic              wr;
    logic              row0;
    logic [HSUM_W-1:0] hsum;
    logic [ROW_W-1:0]  out_row;
    logic              eol;
    logic              eof;
    logic              last;
  } col_op_t;

endpackage

FILE: rtl/bbg_ram.sv
// ----------------------------------------------------------------------------
// bbg_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bbg_fifo.sv
// ----------------------------------------------------------------------------
// bbg_fifo: short register queue
// Decouples the column sequencer from the line store pipeline.
// ----------------------------------------------------------------------------
module bbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bbg_pkg::QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/bbg_front.sv
// ----------------------------------------------------------------------------
// bbg_front: raster position tracking and column operation issue
// Accepts pixel and drain items, forms horizontal three-pixel sums and
// turns each item into zero, one or two column operations for the queue.
// ----------------------------------------------------------------------------
module bbg_front #(
  parameter int MAX_WIDTH = bbg_pkg::MAX_WIDTH_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbg_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  bbg_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  output logic              push_o,
  output bbg_pkg::col_op_t  op_o,
  output logic [CW-1:0]     idx_o,
  input  logic              full_i
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > bbg_pkg::LINE_WIDTH_W) ? WW : bbg_pkg::LINE_WIDTH_W;

  logic [bbg_pkg::PIXEL_W-1:0]   lf_q, ln_q;
  logic [CW-1:0]                 col_q;
  logic [bbg_pkg::ROW_W-1:0]     row_q;
  logic                          drain_q;
  logic                          pend_q;
  bbg_pkg::col_op_t              pend_op_q;
  logic [CW-1:0]                 pend_idx_q;

  logic [CMPW-1:0]               lw_ext, max_ext, w_eff, wm1;
  logic [bbg_pkg::ROW_W-1:0]     hm1;
  logic                          last_col, last_row, accept, is_drain;
  logic [bbg_pkg::PIXEL_W-1:0]   pix, near;
  logic [bbg_pkg::HSUM_W-1:0]    b3, hsum_a, hsum_b;
  bbg_pkg::col_op_t              op_a, op_b, op_d;
  logic                          has_a, has_b, load_pend;

  // Effective frame geometry
  assign lw_ext   = CMPW'(cfg_i.line_width);
  assign max_ext  = CMPW'(MAX_WIDTH);
  assign w_eff    = (lw_ext == '0) ? CMPW'(1) : ((lw_ext > max_ext) ? max_ext : lw_ext);
  assign wm1      = w_eff - CMPW'(1);
  assign last_col = (CMPW'(col_q) >= wm1);
  assign hm1      = (cfg_i.frame_height == '0) ? '0 : cfg_i.frame_height - 16'd1;
  assign last_row = (row_q >= hm1);

  assign in_stall_o = pend_q || full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_drain   = (in_data_i.command == bbg_pkg::CMD_DRAIN);
  assign pix        = in_data_i.pixel_in;

  // Horizontal sums: column c-1, and column c with the right border
  assign near   = (col_q == '0) ? cfg_i.border_value : ln_q;
  assign b3     = bbg_pkg::HSUM_W'(cfg_i.border_value) + bbg_pkg::HSUM_W'(cfg_i.border_value)
                + bbg_pkg::HSUM_W'(cfg_i.border_value);
  assign hsum_a = bbg_pkg::HSUM_W'(lf_q) + bbg_pkg::HSUM_W'(ln_q) + bbg_pkg::HSUM_W'(pix);
  assign hsum_b = bbg_pkg::HSUM_W'(near) + bbg_pkg::HSUM_W'(pix)
                + bbg_pkg::HSUM_W'(cfg_i.border_value);

  assign has_a = (col_q != '0);
  assign has_b = last_col;

  // Build the candidate operations
  always_comb begin
    op_a         = '0;
    op_a.emit    = (row_q != '0);
    op_a.wr      = 1'b1;
    op_a.row0    = (row_q == '0);
    op_a.hsum    = hsum_a;
    op_a.out_row = row_q - 16'd1;
    op_a.last    = !has_b;

    op_b         = op_a;
    op_b.hsum    = hsum_b;
    op_b.eol     = 1'b1;
    op_b.last    = 1'b1;

    op_d         = '0;
    op_d.emit    = 1'b1;
    op_d.hsum    = b3;
    op_d.out_row = row_q;
    op_d.eol     = last_col;
    op_d.eof     = last_col;
    op_d.last    = 1'b1;
  end

  // Select what goes to the queue this cycle
  always_comb begin
    push_o    = 1'b0;
    op_o      = op_a;
    idx_o     = col_q - CW'(1);
    load_pend = 1'b0;
    if (pend_q) begin
      push_o = !full_i;
      op_o   = pend_op_q;
      idx_o  = pend_idx_q;
    end else if (accept && is_drain) begin
      push_o = drain_q;
      op_o   = op_d;
      idx_o  = col_q;
    end else if (accept && !drain_q) begin
      if (has_a) begin
        push_o    = 1'b1;
        load_pend = has_b;
      end else begin
        push_o = has_b;
        op_o   = op_b;
        idx_o  = col_q;
      end
    end
  end

  // Hold the raster position and the left-hand pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q    <= '0;
      ln_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (pend_q && !full_i) begin
        pend_q <= 1'b0;
      end else if (load_pend) begin
        pend_q <= 1'b1;
      end
      if (accept && is_drain && drain_q) begin
        if (last_col) begin
          drain_q <= 1'b0;
          row_q   <= '0;
          col_q   <= '0;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else if (accept && !is_drain && !drain_q) begin
        lf_q <= (col_q == '0) ? cfg_i.border_value : ln_q;
        ln_q <= pix;
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            drain_q <= 1'b1;
          end else begin
            row_q <= row_q + 16'd1;
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // Park the second operation of a row end
  always_ff @(posedge clk_i) begin
    if (load_pend) begin
      pend_op_q  <= op_b;
      pend_idx_q <= col_q;
    end
  end

endmodule

FILE: rtl/bbg_back.sv
// ----------------------------------------------------------------------------
// bbg_back: line store pipeline and mean computation
// Reads both line stores of a column, adds the new horizontal sum, writes
// the shifted sums back and scales the nine-pixel sum to the mean.
// ----------------------------------------------------------------------------
module bbg_back #(
  parameter int MAX_WIDTH = bbg_pkg::MAX_WIDTH_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bbg_pkg::PIXEL_W-1:0] border_value_i,
  input  logic                        empty_i,
  input  bbg_pkg::col_op_t            head_op_i,
  input  logic [CW-1:0]               head_idx_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  output bbg_pkg::out_item_t          out_data_o,
  input  logic                        out_stall_i
);

  localparam int HW   = bbg_pkg::HSUM_W;
  localparam int SW   = bbg_pkg::NSUM_W;
  localparam int PRW  = SW + bbg_pkg::MEAN_MUL_W;

  logic                 advance;
  logic                 a_valid_q, b_valid_q, out_valid_q, fwd_hit_q;
  bbg_pkg::col_op_t     a_op_q;
  logic [CW-1:0]        a_idx_q;
  logic [2*HW-1:0]      fwd_data_q, rdata, pair, wdata;
  logic [HW-1:0]        older, newer, b3;
  logic                 we, fwd_hit_d;
  logic [SW-1:0]        sum_d, b_sum_q;
  bbg_pkg::col_op_t     b_op_q;
  logic [CW-1:0]        b_idx_q;
  logic [PRW-1:0]       prod;
  bbg_pkg::out_item_t   out_q;

  // Whole pipeline moves together when the output register can take a result
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !empty_i;

  // Column line stores: {older, newer}
  bbg_ram #(
    .WIDTH (2*HW),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (a_idx_q),
    .wdata_i (wdata),
    .re_i    (pop_o),
    .raddr_i (head_idx_i),
    .rdata_o (rdata)
  );

  // Stage A: bypass a same-edge write, sum nine pixels, form write-back
  assign b3    = HW'(border_value_i) + HW'(border_value_i) + HW'(border_value_i);
  assign pair  = fwd_hit_q ? fwd_data_q : rdata;
  assign older = pair[2*HW-1:HW];
  assign newer = pair[HW-1:0];
  assign sum_d = SW'(older) + SW'(newer) + SW'(a_op_q.hsum) + SW'(1);
  assign wdata = a_op_q.row0 ? {b3, a_op_q.hsum} : {newer, a_op_q.hsum};
  assign we    = advance && a_valid_q && a_op_q.wr;
  assign fwd_hit_d = pop_o && we && (a_idx_q == head_idx_i);

  // Stage B: scale to the mean
  assign prod = PRW'(b_sum_q) * PRW'(bbg_pkg::MEAN_MUL);

  // Control state of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= !empty_i;
      b_valid_q   <= a_valid_q && a_op_q.emit;
      out_valid_q <= b_valid_q;
      fwd_hit_q   <= fwd_hit_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_op_q     <= head_op_i;
      a_idx_q    <= head_idx_i;
      fwd_data_q <= wdata;
      b_sum_q    <= sum_d;
      b_op_q     <= a_op_q;
      b_idx_q    <= a_idx_q;
      out_q.blurred      <= prod[bbg_pkg::MEAN_SHIFT +: bbg_pkg::PIXEL_W];
      out_q.out_row      <= b_op_q.out_row;
      out_q.out_col      <= bbg_pkg::COL_W'(b_idx_q);
      out_q.end_of_line  <= b_op_q.eol;
      out_q.end_of_frame <= b_op_q.eof;
      out_q.last_of_run  <= b_op_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/box_blur_3x3_gray.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_gray: streaming 3x3 mean filter for 8-bit gray pixels
// Border-padded box filter, output one row behind the input; drain items
// emit the last row of the frame.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       sink       in_valid_i / in_stall_o    in_data_i  (command, pixel_in)
//  out      source     out_valid_o / out_stall_i  out_data_o (blurred, row, col,
//                                                  end_of_line/frame, last_of_run)
//  cfg      APB slave  psel/penable/pready        line_width, frame_height,
//                                                  border_value at 0x0/0x4/0x8
//
//  One item per cycle while in_stall_o is low; a row's last-column pixel gives
//  two column operations and holds in_stall_o while the second is queued, as
//  the single line store read port serves one column per cycle unless stalled.
//  Items pass the queue, line store read, sum and multiply stages.
//  Reset clears position and control state only; line stores need no clearing
//  pass, so items are taken right after reset.
//  A stalled output freezes the back pipeline; the queue keeps the input open
//  until it is full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module box_blur_3x3_gray #(
  parameter int MAX_WIDTH = bbg_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  bbg_pkg::in_item_t              in_data_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output bbg_pkg::out_item_t             out_data_o,
  input  logic                           out_stall_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bbg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bbg_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = $bits(bbg_pkg::col_op_t) + CW;

  bbg_pkg::cfg_t     cfg_q;
  bbg_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  logic              push, full, pop, empty;
  bbg_pkg::col_op_t  fe_op, head_op;
  logic [CW-1:0]     fe_idx, head_idx;
  logic [QW-1:0]     q_wdata, q_rdata;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bbg_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width   <= bbg_pkg::LINE_WIDTH_RST;
      cfg_q.frame_height <= bbg_pkg::FRAME_HEIGHT_RST;
      cfg_q.border_value <= bbg_pkg::BORDER_VALUE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bbg_pkg::REG_LINE_WIDTH:
          cfg_q.line_width <= pwdata[bbg_pkg::LINE_WIDTH_W-1:0];
        bbg_pkg::REG_FRAME_HEIGHT:
          cfg_q.frame_height <= pwdata[bbg_pkg::FRAME_HEIGHT_W-1:0];
        bbg_pkg::REG_BORDER_VALUE:
          cfg_q.border_value <= pwdata[bbg_pkg::PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      bbg_pkg::REG_LINE_WIDTH:   prdata = bbg_pkg::APB_DATA_W'(cfg_q.line_width);
      bbg_pkg::REG_FRAME_HEIGHT: prdata = bbg_pkg::APB_DATA_W'(cfg_q.frame_height);
      bbg_pkg::REG_BORDER_VALUE: prdata = bbg_pkg::APB_DATA_W'(cfg_q.border_value);
      default:                   prdata = '0;
    endcase
  end

  // Front end: raster tracking and operation issue
  bbg_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .op_o       (fe_op),
    .idx_o      (fe_idx),
    .full_i     (full)
  );

  // Operation queue
  assign q_wdata = {fe_op, fe_idx};
  assign head_op  = q_rdata[QW-1:CW];
  assign head_idx = q_rdata[CW-1:0];

  bbg_fifo #(
    .WIDTH (QW),
    .DEPTH (bbg_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  // Back end: line stores and mean
  bbg_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .border_value_i (cfg_q.border_value),
    .empty_i        (empty),
    .head_op_i      (head_op),
    .head_idx_i     (head_idx),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

FILE: rtl/bbg_checker.sv
// ----------------------------------------------------------------------------
// bbg_checker: port-level checks of the box blur output stream
// Watches result transfers and their framing flags.
// ----------------------------------------------------------------------------
module bbg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bbg_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Frame end comes only from a drain item, on the last column
  a_eof_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |->
      out_data_o.end_of_line && out_data_o.last_of_run)
    else $error("end_of_frame without end_of_line or last_of_run");

  // First result of a row-end pair is never the row's last pixel
  a_pair_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |->
      !out_data_o.end_of_line && !out_data_o.end_of_frame)
    else $error("non-final result of an item flagged as row end");

endmodule

bind box_blur_3x3_gray bbg_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
